[hdl/sfm_pkg.sv]
package sfm_pkg;

    // Widths of the configuration port and of the result fields.
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 8;
    localparam int SERVO_BITS    = 8;
    localparam int MODE_BITS     = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_FOLD_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MOTOR_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_INTERVAL   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PWM_RETRACTED   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PWM_EXTENDED    = 3'd4;

    // Values of the configuration registers after reset.
    localparam logic [CFG_DATA_BITS-1:0] RST_FOLD_THRESHOLD  = 8'd65;
    localparam logic [CFG_DATA_BITS-1:0] RST_MOTOR_THRESHOLD = 8'd95;
    localparam logic [CFG_DATA_BITS-1:0] RST_RAMP_INTERVAL   = 8'd20;
    localparam logic [CFG_DATA_BITS-1:0] RST_PWM_RETRACTED   = 8'd16;
    localparam logic [CFG_DATA_BITS-1:0] RST_PWM_EXTENDED    = 8'd28;

    // Sequencer modes, encoded as they appear on the result channel.
    typedef enum logic [MODE_BITS-1:0] {
        MODE_OFF       = 3'd0,
        MODE_FOLD_OUT  = 3'd1,
        MODE_OUT       = 3'd2,
        MODE_RAMP_UP   = 3'd3,
        MODE_MOTOR_ON  = 3'd4,
        MODE_RAMP_DOWN = 3'd5,
        MODE_MOTOR_OFF = 3'd6,
        MODE_FOLD_IN   = 3'd7
    } t_mode;

    // Configuration register set.
    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] fold_threshold;
        logic [CFG_DATA_BITS-1:0] motor_threshold;
        logic [CFG_DATA_BITS-1:0] ramp_interval;
        logic [CFG_DATA_BITS-1:0] pwm_retracted;
        logic [CFG_DATA_BITS-1:0] pwm_extended;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [SERVO_BITS-1:0] servo_compare;
        logic                  motor_led;
        t_mode                 mode_code;
    } t_result;

endpackage

[hdl/sfm_in_if.sv]
interface sfm_in_if #(
    parameter int CHANNEL_BITS = 8
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] channel_value;

    modport source (output valid, output channel_value, input ready);
    modport sink (input valid, input channel_value, output ready);
endinterface

[hdl/sfm_out_if.sv]
interface sfm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] servo_compare;
    logic       motor_led;
    logic [2:0] mode_code;

    modport source (output valid, output servo_compare, output motor_led,
                    output mode_code, input ready);
    modport sink (input valid, input servo_compare, input motor_led,
                  input mode_code, output ready);
endinterface

[hdl/sfm_ctrl.sv]
module sfm_ctrl
    import sfm_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [CHANNEL_BITS-1:0] i_ch,
    input  t_cfg                    i_cfg,
    output t_result                 o_next
);

    t_mode                    r_mode;
    logic [CFG_DATA_BITS-1:0] r_ramp_ticks;
    logic [SERVO_BITS-1:0]    r_servo;
    logic                     r_led;

    t_mode                    n_mode;
    logic [CFG_DATA_BITS-1:0] n_ramp_ticks;
    logic [SERVO_BITS-1:0]    n_servo;
    logic                     n_led;

    logic [CHANNEL_BITS-1:0]  fold_thr;
    logic [CHANNEL_BITS-1:0]  motor_thr;
    logic                     ch_below_fold;
    logic                     ch_above_fold;
    logic                     ch_below_motor;
    logic                     ch_above_motor;
    logic [CFG_DATA_BITS-1:0] ramp_inc;
    logic                     ramp_hit;
    logic [SERVO_BITS-1:0]    servo_up;
    logic [SERVO_BITS-1:0]    servo_dn;

    // Threshold compares on the channel value.
    assign fold_thr       = CHANNEL_BITS'(i_cfg.fold_threshold);
    assign motor_thr      = CHANNEL_BITS'(i_cfg.motor_threshold);
    assign ch_below_fold  = i_ch < fold_thr;
    assign ch_above_fold  = i_ch > fold_thr;
    assign ch_below_motor = i_ch < motor_thr;
    assign ch_above_motor = i_ch > motor_thr;

    // Ramp timer and the servo step in either direction.
    assign ramp_inc = r_ramp_ticks + 8'd1;
    assign ramp_hit = ramp_inc >= i_cfg.ramp_interval;
    assign servo_up = r_servo + 8'd1;
    assign servo_dn = r_servo - 8'd1;

    // Next mode. Later checks in each arm take priority over earlier ones.
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_OFF: begin
                if (!ch_below_fold) n_mode = MODE_FOLD_OUT;
            end
            MODE_FOLD_OUT: begin
                if (ramp_hit && (servo_up >= i_cfg.pwm_extended)) n_mode = MODE_OUT;
                if (ch_below_fold) n_mode = MODE_FOLD_IN;
            end
            MODE_OUT: begin
                if (ch_below_fold) n_mode = MODE_FOLD_IN;
                if (ch_above_motor) n_mode = MODE_RAMP_UP;
            end
            MODE_RAMP_UP: begin
                n_mode = MODE_MOTOR_ON;
            end
            MODE_MOTOR_ON: begin
                if (ch_below_motor) n_mode = MODE_RAMP_DOWN;
            end
            MODE_RAMP_DOWN: begin
                if (ch_below_fold) n_mode = MODE_FOLD_IN;
                if (ch_above_motor) n_mode = MODE_RAMP_UP;
            end
            MODE_MOTOR_OFF: begin
                n_mode = MODE_OFF;
            end
            MODE_FOLD_IN: begin
                if (ramp_hit && (servo_dn <= i_cfg.pwm_retracted)) n_mode = MODE_OFF;
                if (ch_above_fold) n_mode = MODE_FOLD_OUT;
            end
            default: begin
                n_mode = MODE_OFF;
            end
        endcase
    end

    // Servo value, ramp timer and motor indicator for the current mode.
    always_comb begin
        n_ramp_ticks = r_ramp_ticks;
        n_servo      = r_servo;
        n_led        = r_led;
        unique case (r_mode)
            MODE_OFF: begin
                n_servo      = i_cfg.pwm_retracted;
                n_ramp_ticks = '0;
            end
            MODE_FOLD_OUT: begin
                n_ramp_ticks = ramp_hit ? '0 : ramp_inc;
                if (ramp_hit) n_servo = servo_up;
            end
            MODE_OUT: begin
                n_servo = i_cfg.pwm_extended;
            end
            MODE_MOTOR_ON: begin
                n_led = 1'b1;
            end
            MODE_RAMP_DOWN: begin
                n_led = 1'b0;
                if (ch_below_fold || ch_above_motor) n_ramp_ticks = '0;
            end
            MODE_FOLD_IN: begin
                n_ramp_ticks = ramp_hit ? '0 : ramp_inc;
                if (ramp_hit) n_servo = servo_dn;
            end
            default: begin
                n_ramp_ticks = r_ramp_ticks;
            end
        endcase
    end

    // Sequencer state advances once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_OFF;
            r_ramp_ticks <= '0;
            r_servo      <= '0;
            r_led        <= 1'b0;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_ramp_ticks <= n_ramp_ticks;
            r_servo      <= n_servo;
            r_led        <= n_led;
        end
    end

    assign o_next.servo_compare = n_servo;
    assign o_next.motor_led     = n_led;
    assign o_next.mode_code     = n_mode;

endmodule

[hdl/servo_fold_motor_sequencer_core.sv]
// Servo fold and motor sequencer.
// Input channel i_in: one transfer per control tick, carrying the measured
// remote-control channel value. Output channel o_out: one transfer per tick
// with the servo compare value, the motor indicator and the mode after that
// tick. Both channels use a valid/ready handshake.
// The configuration port writes thresholds, ramp interval and the two servo
// end positions; write it only while no tick is in flight.
// An input transfer lands in an input register; when the output register is
// free or is being emptied, the mode logic runs and the result lands in the
// output register, from which it is offered on the output channel.
// One tick per cycle is accepted as long as the receiver takes results; the
// mode machine update is combinational compares and 8-bit increments and
// decrements.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more tick before ready drops.
// Reset (synchronous, active low) puts the sequencer in the off mode with the
// servo value, ramp timer and motor indicator cleared, loads the register
// defaults and empties both stages.
module servo_fold_motor_sequencer_core
    import sfm_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    sfm_in_if.sink                   i_in,
    sfm_out_if.source                o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg                    r_cfg;
    logic                    r_in_valid;
    logic [CHANNEL_BITS-1:0] r_ch;
    logic                    r_out_valid;
    t_result                 r_res;

    t_result                 step_res;
    logic                    step;
    logic                    in_ready;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fold_threshold  <= RST_FOLD_THRESHOLD;
            r_cfg.motor_threshold <= RST_MOTOR_THRESHOLD;
            r_cfg.ramp_interval   <= RST_RAMP_INTERVAL;
            r_cfg.pwm_retracted   <= RST_PWM_RETRACTED;
            r_cfg.pwm_extended    <= RST_PWM_EXTENDED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FOLD_THRESHOLD:  r_cfg.fold_threshold  <= i_cfg_data;
                REG_MOTOR_THRESHOLD: r_cfg.motor_threshold <= i_cfg_data;
                REG_RAMP_INTERVAL:   r_cfg.ramp_interval   <= i_cfg_data;
                REG_PWM_RETRACTED:   r_cfg.pwm_retracted   <= i_cfg_data;
                REG_PWM_EXTENDED:    r_cfg.pwm_extended    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The item in the input register moves on when the output register is
    // free or is being emptied in this cycle.
    assign step     = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && in_ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_ch <= i_in.channel_value;
        end
    end

    // Mode machine.
    sfm_ctrl #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_ch    (r_ch),
        .i_cfg   (r_cfg),
        .o_next  (step_res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= step_res;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.servo_compare = r_res.servo_compare;
    assign o_out.motor_led     = r_res.motor_led;
    assign o_out.mode_code     = MODE_BITS'(r_res.mode_code);

endmodule

[tb/servo_fold_motor_sequencer_core_test.sv]
`timescale 1ns / 100ps

module servo_fold_motor_sequencer_core_test;
    import sfm_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 300;
    localparam int PHASES       = 12;
    localparam int LONG_ITEMS   = 300;
    localparam int SHORT_ITEMS  = 95;
    localparam int REPORT_LIMIT = 10;

    // First index past the mapped registers; writes there must be ignored.
    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = REG_PWM_EXTENDED + 3'd1;

    // Channel levels that the random stimulus holds for a run of ticks.
    typedef enum int {
        LVL_ZERO,
        LVL_FULL,
        LVL_BELOW_FOLD,
        LVL_AT_FOLD,
        LVL_ABOVE_FOLD,
        LVL_BELOW_MOTOR,
        LVL_AT_MOTOR,
        LVL_ABOVE_MOTOR,
        LVL_BETWEEN,
        LVL_ANY,
        LVL_COUNT
    } t_level;

    // One row of the directed table: a register write or a tick.
    typedef struct {
        bit                       is_write;
        logic [CFG_IDX_BITS-1:0]  reg_idx;
        logic [7:0]               value;
        bit                       typed;
        t_result                  want;
    } t_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    sfm_in_if #(.CHANNEL_BITS(8)) in_ch ();
    sfm_out_if                    out_ch ();

    servo_fold_motor_sequencer_core #(
        .CHANNEL_BITS(8)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Register copy and sequencer state of the predictor.
    t_cfg       regs;
    t_mode      seq_mode;
    logic [7:0] seq_ticks;
    logic [7:0] seq_servo;
    logic       seq_led;

    t_result    pending_results[$];
    t_row       directed_rows[$];
    int         fail_count = 0;
    int         cycle_count = 0;
    bit         hold_request = 0;

    // Clock generation.
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("servo_fold_motor_sequencer_core_test NOT OK");
            $finish;
        end
    end

    // Predictor state after reset.
    function automatic void reset_sequencer();
        regs.fold_threshold  = RST_FOLD_THRESHOLD;
        regs.motor_threshold = RST_MOTOR_THRESHOLD;
        regs.ramp_interval   = RST_RAMP_INTERVAL;
        regs.pwm_retracted   = RST_PWM_RETRACTED;
        regs.pwm_extended    = RST_PWM_EXTENDED;
        seq_mode  = MODE_OFF;
        seq_ticks = 8'd0;
        seq_servo = 8'd0;
        seq_led   = 1'b0;
    endfunction

    function automatic void apply_write(logic [CFG_IDX_BITS-1:0] idx, logic [7:0] val);
        case (idx)
            REG_FOLD_THRESHOLD:  regs.fold_threshold  = val;
            REG_MOTOR_THRESHOLD: regs.motor_threshold = val;
            REG_RAMP_INTERVAL:   regs.ramp_interval   = val;
            REG_PWM_RETRACTED:   regs.pwm_retracted   = val;
            REG_PWM_EXTENDED:    regs.pwm_extended    = val;
            default: ;
        endcase
    endfunction

    // The ramp timer counts ticks and reports when a servo step is due.
    function automatic bit ramp_due();
        seq_ticks = seq_ticks + 8'd1;
        if (seq_ticks >= regs.ramp_interval) begin
            seq_ticks = 8'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // One tick of the mode machine; returns the result it causes.
    function automatic t_result advance_sequencer(logic [7:0] ch);
        t_result r;
        case (seq_mode)
            MODE_OFF: begin
                seq_servo = regs.pwm_retracted;
                seq_ticks = 8'd0;
                if (ch >= regs.fold_threshold) seq_mode = MODE_FOLD_OUT;
            end
            MODE_FOLD_OUT: begin
                if (ramp_due()) begin
                    seq_servo = seq_servo + 8'd1;
                    if (seq_servo >= regs.pwm_extended) seq_mode = MODE_OUT;
                end
                if (ch < regs.fold_threshold) seq_mode = MODE_FOLD_IN;
            end
            MODE_OUT: begin
                seq_servo = regs.pwm_extended;
                if (ch < regs.fold_threshold) seq_mode = MODE_FOLD_IN;
                if (ch > regs.motor_threshold) seq_mode = MODE_RAMP_UP;
            end
            MODE_RAMP_UP: begin
                seq_mode = MODE_MOTOR_ON;
            end
            MODE_MOTOR_ON: begin
                seq_led = 1'b1;
                if (ch < regs.motor_threshold) seq_mode = MODE_RAMP_DOWN;
            end
            MODE_RAMP_DOWN: begin
                seq_led = 1'b0;
                if (ch < regs.fold_threshold) begin
                    seq_mode  = MODE_FOLD_IN;
                    seq_ticks = 8'd0;
                end
                if (ch > regs.motor_threshold) begin
                    seq_mode  = MODE_RAMP_UP;
                    seq_ticks = 8'd0;
                end
            end
            MODE_FOLD_IN: begin
                if (ramp_due()) begin
                    seq_servo = seq_servo - 8'd1;
                    if (seq_servo <= regs.pwm_retracted) seq_mode = MODE_OFF;
                end
                if (ch > regs.fold_threshold) seq_mode = MODE_FOLD_OUT;
            end
            default: begin
                seq_mode = MODE_OFF;
            end
        endcase
        r.servo_compare = seq_servo;
        r.motor_led     = seq_led;
        r.mode_code     = seq_mode;
        return r;
    endfunction

    // Channel value for a level, relative to the current thresholds.
    function automatic logic [7:0] level_value(t_level lvl);
        int span;
        case (lvl)
            LVL_ZERO:        return 8'd0;
            LVL_FULL:        return 8'hFF;
            LVL_BELOW_FOLD:  return regs.fold_threshold - 8'd1;
            LVL_AT_FOLD:     return regs.fold_threshold;
            LVL_ABOVE_FOLD:  return regs.fold_threshold + 8'd1;
            LVL_BELOW_MOTOR: return regs.motor_threshold - 8'd1;
            LVL_AT_MOTOR:    return regs.motor_threshold;
            LVL_ABOVE_MOTOR: return regs.motor_threshold + 8'd1;
            LVL_BETWEEN: begin
                span = int'(regs.motor_threshold) - int'(regs.fold_threshold);
                if (span < 0) return 8'($urandom);
                return 8'(int'(regs.fold_threshold) + $urandom_range(0, span));
            end
            default:         return 8'($urandom);
        endcase
    endfunction

    // Directed table builders.
    function automatic void add_write(logic [CFG_IDX_BITS-1:0] idx, logic [7:0] val);
        t_row row;
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.value    = val;
        row.typed    = 1'b0;
        row.want     = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_tick(logic [7:0] ch);
        t_row row;
        row.is_write = 1'b0;
        row.reg_idx  = '0;
        row.value    = ch;
        row.typed    = 1'b0;
        row.want     = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_typed(logic [7:0] ch, logic [7:0] servo, logic led,
                                      t_mode mode);
        t_row row;
        row.is_write           = 1'b0;
        row.reg_idx            = '0;
        row.value              = ch;
        row.typed              = 1'b1;
        row.want.servo_compare = servo;
        row.want.motor_led     = led;
        row.want.mode_code     = mode;
        directed_rows.push_back(row);
    endfunction

    // Register write; the block is idle whenever this is called.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        apply_write(idx, val);
    endtask

    // Offer one tick and hold it until the transfer happens.
    task automatic send_tick(input logic [7:0] ch, input bit typed, input t_result want);
        t_result predicted;
        @(negedge i_clk);
        in_ch.valid         <= 1'b1;
        in_ch.channel_value <= ch;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = advance_sequencer(ch);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
    endtask

    // Stop offering and wait until every pending result has been taken.
    task automatic wait_drained();
        idle_sender(1);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register settings of one random phase: reset defaults first, then extremes.
    task automatic configure_phase(input int phase);
        logic [7:0] fold, motor, interval, retracted, extended;
        fold      = 8'($urandom);
        motor     = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(fold, 255)) : 8'($urandom);
        interval  = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
        retracted = 8'($urandom);
        extended  = retracted + 8'($urandom_range(0, 6));
        case (phase)
            0: begin
                fold      = RST_FOLD_THRESHOLD;
                motor     = RST_MOTOR_THRESHOLD;
                interval  = RST_RAMP_INTERVAL;
                retracted = RST_PWM_RETRACTED;
                extended  = RST_PWM_EXTENDED;
            end
            1: begin
                fold      = 8'd0;
                motor     = 8'd0;
                interval  = 8'd0;
                retracted = 8'd0;
                extended  = 8'd0;
            end
            2: begin
                fold      = 8'hFF;
                motor     = 8'hFF;
                interval  = 8'd1;
                retracted = 8'd0;
                extended  = 8'hFF;
            end
            3: begin
                interval  = 8'hFF;
                extended  = retracted + 8'd1;
            end
            4: begin
                interval  = 8'd1;
                retracted = 8'hFF;
                extended  = 8'd0;
            end
            default: ;
        endcase
        write_reg(REG_FOLD_THRESHOLD, fold);
        write_reg(REG_MOTOR_THRESHOLD, motor);
        write_reg(REG_RAMP_INTERVAL, interval);
        write_reg(REG_PWM_RETRACTED, retracted);
        write_reg(REG_PWM_EXTENDED, extended);
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_UNMAPPED + 3'($urandom_range(0, 2)), 8'($urandom));
    endtask

    // Receiver: a ready pattern renewed each time the slot counter wraps, with a long hold on request.
    initial begin
        int         hold_left;
        int         slot;
        logic [15:0] pattern;
        hold_left = 0;
        slot      = 0;
        pattern   = '1;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (slot == 0)
                    pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
                out_ch.ready <= pattern[slot % 16];
                slot = (slot + 1) % 64;
            end
        end
    end

    // Result checker: every transfer on the output is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.servo_compare = out_ch.servo_compare;
            got.motor_led     = out_ch.motor_led;
            got.mode_code     = t_mode'(out_ch.mode_code);
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result: servo %0d led %0d mode %0d",
                             got.servo_compare, got.motor_led, got.mode_code);
            end else begin
                want = pending_results.pop_front();
                if (got.servo_compare !== want.servo_compare ||
                    got.motor_led !== want.motor_led ||
                    got.mode_code !== want.mode_code) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("mismatch: expected servo %0d led %0d mode %0d, got servo %0d led %0d mode %0d",
                                 want.servo_compare, want.motor_led, want.mode_code,
                                 got.servo_compare, got.motor_led, got.mode_code);
                end
            end
        end
    end

    // Stimulus.
    initial begin
        int         phase;
        int         left;
        int         run_len;
        int         run_max;
        int         burst_left;
        int         noise_odds;
        bit         steady;
        bit         long_phase;
        t_level     lvl;
        logic [7:0] ch;
        t_result    none;

        none                = '0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.channel_value = '0;
        reset_sequencer();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: reset defaults, threshold edges and every mode but
        // MODE_MOTOR_OFF, which no transition reaches.
        add_typed(8'd0, RST_PWM_RETRACTED, 1'b0, MODE_OFF);
        add_typed(RST_FOLD_THRESHOLD - 8'd1, RST_PWM_RETRACTED, 1'b0, MODE_OFF);
        add_typed(RST_FOLD_THRESHOLD, RST_PWM_RETRACTED, 1'b0, MODE_FOLD_OUT);
        add_write(REG_RAMP_INTERVAL, 8'd1);
        add_write(REG_PWM_EXTENDED, 8'd19);
        add_tick(8'd200);
        add_tick(8'd200);
        add_tick(8'd200);
        add_tick(8'd95);
        add_tick(8'd96);
        add_tick(8'd0);
        add_tick(8'd95);
        add_tick(8'd94);
        add_tick(8'd80);
        add_tick(8'hFF);
        add_tick(8'hFF);
        add_tick(8'd0);
        add_tick(8'd0);
        add_tick(8'd65);
        add_tick(8'd66);
        add_tick(8'd64);
        add_tick(8'd0);
        add_tick(8'd0);
        // Zero ramp interval steps on every tick; an unmapped index is ignored.
        add_write(REG_RAMP_INTERVAL, 8'd0);
        add_write(REG_UNMAPPED + 3'd2, 8'hA5);
        add_tick(8'hFF);
        add_tick(8'hFF);
        add_tick(8'hFF);
        add_tick(8'hAA);
        add_tick(8'h55);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_write) begin
                wait_drained();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end else begin
                send_tick(directed_rows[i].value, directed_rows[i].typed,
                          directed_rows[i].want);
            end
        end

        // Random phases: runs of a held channel level, with noise in the short phases.
        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            configure_phase(phase);
            long_phase = (phase == 0 || phase == 2 || phase == 3);
            left       = long_phase ? LONG_ITEMS : SHORT_ITEMS;
            run_max    = long_phase ? 300 : 40;
            noise_odds = long_phase ? 0 : 16;
            steady     = (phase % 4 == 1) || (phase == 5);
            burst_left = 0;
            if (phase == 5) hold_request = 1'b1;
            while (left > 0) begin
                if (long_phase && $urandom_range(0, 1) == 0)
                    lvl = LVL_FULL;
                else
                    lvl = t_level'($urandom_range(0, LVL_COUNT - 1));
                run_len = $urandom_range(1, run_max);
                if ($urandom_range(0, 15) == 0) wait_drained();
                while (run_len > 0 && left > 0) begin
                    ch = level_value(lvl);
                    if (noise_odds != 0 && $urandom_range(0, noise_odds - 1) == 0)
                        ch = 8'($urandom);
                    if (!steady) begin
                        if (burst_left == 0) begin
                            idle_sender($urandom_range(1, 6));
                            burst_left = $urandom_range(1, 24);
                        end
                        burst_left--;
                    end
                    send_tick(ch, 1'b0, none);
                    run_len--;
                    left--;
                end
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("servo_fold_motor_sequencer_core_test OK");
        end else begin
            $display("servo_fold_motor_sequencer_core_test NOT OK");
        end
        $finish;
    end

endmodule
